### rtl/mwf_pkg.sv
package mwf_pkg;

   localparam int MaxWidth  = 1024;
   localparam int MaxKernel = 7;
   localparam int StoreRows = 8;
   localparam int ColBits   = $clog2(MaxWidth);
   localparam int RowBits   = $clog2(StoreRows);
   localparam int AddrBits  = ColBits + RowBits;
   localparam int MemDepth  = StoreRows * MaxWidth;

   // register indexes on the csr port
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_KERNEL_SIZE  = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] pixel_in;
   } req_pkt_type;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic       frame_end;
   } rsp_pkt_type;

   typedef struct packed {
      logic [10:0] frame_width;
      logic [10:0] frame_height;
      logic [2:0]  kernel_size;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PASS,
      ST_PDATA,
      ST_SCAN,
      ST_DECIDE,
      ST_DONE
   } state_type;

   // zero-based rank of the median in a (2r+1)^2 window
   function automatic logic [5:0] median_rank(input logic [1:0] radius);
      logic [5:0] rank;
      begin
         unique case (radius)
            2'd0: rank = 6'd0;
            2'd1: rank = 6'd4;
            2'd2: rank = 6'd12;
            default: rank = 6'd24;
         endcase
         return rank;
      end
   endfunction

endpackage

### rtl/mwf_csr.sv
module mwf_csr
   import mwf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   logic       wr_fire;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= 11'd640;
         cfg_ff.frame_height <= 11'd480;
         cfg_ff.kernel_size  <= 3'd3;
      end else if (wr_fire) begin
         unique case (reg_idx)
            REG_FRAME_WIDTH:  cfg_ff.frame_width  <= csr_pwdata[10:0];
            REG_FRAME_HEIGHT: cfg_ff.frame_height <= csr_pwdata[10:0];
            REG_KERNEL_SIZE:  cfg_ff.kernel_size  <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_FRAME_WIDTH:  csr_prdata = {21'd0, cfg_ff.frame_width};
         REG_FRAME_HEIGHT: csr_prdata = {21'd0, cfg_ff.frame_height};
         REG_KERNEL_SIZE:  csr_prdata = {29'd0, cfg_ff.kernel_size};
         default:          csr_prdata = 32'd0;
      endcase
   end

endmodule

### rtl/median_window_filter.sv
// Streaming k-by-k median filter for 8-bit greyscale frames in raster order.
// Input rows sit in an 8-row by 1024-pixel line store with one write and one
// read port. An item that is ignored or only fills the pipeline lag gives no
// result; a border pixel (or any pixel with even k) is read back from the line
// store, and a median pixel is found by an 8-pass bit-serial search that reads
// the k*k window samples from the line store one per cycle on each pass. After
// reset the line store is cleared, during which req_ready stays low; csr writes
// are taken throughout.
module median_window_filter
   import mwf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_pkt_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_pkt_type rsp_payload,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg;

   mwf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   state_type state_ff, state_in;

   logic [7:0] line_mem [MemDepth];

   logic [ColBits-1:0]  in_col_ff, out_col_ff, base_col_ff;
   logic [10:0]         in_row_ff, out_row_ff;
   logic [11:0]         primed_ff;
   logic [RowBits-1:0]  base_row_ff;
   logic [1:0]          rad_ff;
   logic                last_ff;
   logic [AddrBits-1:0] clr_cnt_ff;
   logic [2:0]          i_ff, j_ff, bit_ff;
   logic [5:0]          cnt_ff;
   logic [7:0]          p_ff, res_ff, rd_data_ff;
   logic                rd_vld_ff;
   logic                rsp_valid_ff;
   rsp_pkt_type         rsp_ff;

   // effective configuration
   logic [10:0] eff_w, eff_h;
   logic [1:0]  rad;
   logic [11:0] lag;
   always_comb begin
      if (cfg.frame_width == 11'd0)       eff_w = 11'd1;
      else if (cfg.frame_width > 11'd1024) eff_w = 11'd1024;
      else                                 eff_w = cfg.frame_width;
      eff_h = (cfg.frame_height == 11'd0) ? 11'd1 : cfg.frame_height;
      rad   = cfg.kernel_size[2:1];
      lag   = 12'({1'b0, eff_w} * {10'd0, rad}) + {10'd0, rad};
   end

   // item decode
   logic req_fire, pix_phase, ignore, do_write, emit, interior, last;
   logic [11:0] orow12, ocol12, w12, h12, r12;
   always_comb begin
      req_fire  = req_valid && req_ready;
      pix_phase = in_row_ff < eff_h;
      ignore    = pix_phase && (req_payload.operation == OP_DRAIN);
      do_write  = req_fire && pix_phase && (req_payload.operation == OP_PIXEL);
      emit      = !ignore && (primed_ff >= lag);
      orow12    = {1'b0, out_row_ff};
      ocol12    = {2'b00, out_col_ff};
      w12       = {1'b0, eff_w};
      h12       = {1'b0, eff_h};
      r12       = {10'd0, rad};
      interior  = cfg.kernel_size[0] && (orow12 >= r12) && (orow12 + r12 < h12)
                  && (ocol12 >= r12) && (ocol12 + r12 < w12);
      last      = (orow12 + 12'd1 >= h12) && (ocol12 + 12'd1 >= w12);
   end

   // window scan address and search step
   logic [2:0]          side_m1;
   logic [5:0]          rank, cnt_sum;
   logic [7:0]          mask, thr, p_next;
   logic                hit, scan_end;
   logic [RowBits-1:0]  scan_row;
   logic [ColBits-1:0]  scan_col;
   always_comb begin
      side_m1  = {rad_ff, 1'b0};
      rank     = median_rank(rad_ff);
      mask     = 8'((9'd1 << bit_ff) - 9'd1);
      thr      = p_ff | mask;
      hit      = rd_vld_ff && (rd_data_ff <= thr);
      cnt_sum  = cnt_ff + {5'd0, hit};
      p_next   = (cnt_sum > rank) ? p_ff : (p_ff | 8'(9'd1 << bit_ff));
      scan_end = (i_ff == side_m1) && (j_ff == side_m1);
      scan_row = base_row_ff + i_ff - {1'b0, rad_ff};
      scan_col = base_col_ff + {7'd0, j_ff} - {8'd0, rad_ff};
   end

   // next state and control
   logic                rd_en, wr_en, rsp_load;
   logic [AddrBits-1:0] rd_addr, wr_addr;
   logic [7:0]          wr_data;
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = {base_row_ff, base_col_ff};
      wr_en     = 1'b0;
      wr_addr   = {in_row_ff[RowBits-1:0], in_col_ff};
      wr_data   = req_payload.pixel_in;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = 8'd0;
            if (&clr_cnt_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            wr_en     = do_write;
            if (req_fire && emit) state_in = interior ? ST_SCAN : ST_PASS;
         end
         ST_PASS: begin
            rd_en    = 1'b1;
            state_in = ST_PDATA;
         end
         ST_PDATA: state_in = ST_DONE;
         ST_SCAN: begin
            rd_en   = 1'b1;
            rd_addr = {scan_row, scan_col};
            if (scan_end) state_in = ST_DECIDE;
         end
         ST_DECIDE: state_in = (bit_ff == 3'd0) ? ST_DONE : ST_SCAN;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   // line store
   always_ff @(posedge clock) begin
      if (wr_en) line_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= line_mem[rd_addr];
   end

   // clearing pass counter and read-valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // raster position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         primed_ff  <= '0;
      end else if (req_fire && !ignore) begin
         if (emit && last) begin
            // frame done, restart every position
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
            primed_ff  <= '0;
         end else begin
            if (pix_phase) begin
               if ({2'b00, in_col_ff} + 12'd1 >= w12) begin
                  in_col_ff <= '0;
                  in_row_ff <= in_row_ff + 11'd1;
               end else begin
                  in_col_ff <= in_col_ff + 1'b1;
               end
            end
            if (!emit) begin
               primed_ff <= primed_ff + 12'd1;
            end else if (ocol12 + 12'd1 >= w12) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + 11'd1;
            end else begin
               out_col_ff <= out_col_ff + 1'b1;
            end
         end
      end
   end

   // per-item work registers and median search
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         base_row_ff <= out_row_ff[RowBits-1:0];
         base_col_ff <= out_col_ff;
         rad_ff      <= rad;
         last_ff     <= last;
         i_ff        <= '0;
         j_ff        <= '0;
         bit_ff      <= 3'd7;
         cnt_ff      <= '0;
         p_ff        <= '0;
      end
      if (state_ff == ST_SCAN) begin
         cnt_ff <= cnt_sum;
         if (j_ff == side_m1) begin
            j_ff <= '0;
            i_ff <= i_ff + 3'd1;
         end else begin
            j_ff <= j_ff + 3'd1;
         end
      end
      if (state_ff == ST_DECIDE) begin
         p_ff   <= p_next;
         bit_ff <= bit_ff - 3'd1;
         cnt_ff <= '0;
         i_ff   <= '0;
         j_ff   <= '0;
         res_ff <= p_next;
      end
      if (state_ff == ST_PDATA) res_ff <= rd_data_ff;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.pixel_out <= res_ff;
         rsp_ff.frame_end <= last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/mwf_checker.sv
module mwf_checker
   import mwf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input rsp_pkt_type rsp_payload,
   input logic        csr_psel,
   input logic        csr_pready
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped or changed while stalled");

   // reset starts the store clearing pass with nothing pending
   assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block ready or holding a result right after reset");

   // a new result only comes out of the busy engine
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while engine was idle");

   // the csr port never stalls
   assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("csr port stalled");

endmodule

bind median_window_filter mwf_checker u_mwf_checker (.*);

### sim/median_window_filter_tb.sv
`timescale 1ns / 100ps

module median_window_filter_tb;
   import mwf_pkg::*;

   localparam int HoldCycles   = 400;
   localparam int SettleCycles = 600;
   localparam int StallLimit   = 50000;
   localparam int ItemTarget   = 1950;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_pkt_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_pkt_type rsp_payload;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   median_window_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // pending requests and expected filtered pixels
   req_pkt_type request_q[$];
   rsp_pkt_type pixel_exp_q[$];

   // shadow of the filter state
   logic [7:0] shadow_lines [0:MemDepth-1];
   int         in_col, in_row, out_col, out_row, fill_count;
   int         cfg_width, cfg_height, cfg_kernel;

   int send_idle_pct, rsp_stall_pct;
   int hold_req, hold_done, hold_left;
   int fail_count, req_count, rsp_count, frame_count, phase_count, queued_items;
   int quiet_cycles;

   function automatic int line_addr(input int row, input int col);
      return (row % StoreRows) * MaxWidth + (col % MaxWidth);
   endfunction

   function automatic int eff_w();
      return (cfg_width == 0) ? 1 : ((cfg_width > MaxWidth) ? MaxWidth : cfg_width);
   endfunction

   function automatic int eff_h();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic int pipe_lag();
      return (cfg_kernel / 2) * eff_w() + cfg_kernel / 2;
   endfunction

   // advance the shadow state by one request, return 1 when a pixel comes out
   function automatic bit filter_step(input req_pkt_type rq, output rsp_pkt_type res);
      int         w, h, k, r, n, i, j;
      logic [7:0] win [0:48];
      logic [7:0] v;
      bit         last;
      w = eff_w();
      h = eff_h();
      k = cfg_kernel;
      r = k / 2;
      res = '0;
      if (in_row < h) begin
         if (rq.operation == OP_DRAIN) return 0;
         shadow_lines[line_addr(in_row, in_col)] = rq.pixel_in;
         if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
         end else begin
            in_col++;
         end
      end
      if (fill_count < r * w + r) begin
         fill_count++;
         return 0;
      end
      if ((k % 2 == 1) && out_row >= r && out_row + r < h && out_col >= r &&
          out_col + r < w) begin
         // gather the window and insertion sort it
         n = 0;
         for (i = 0; i < 2 * r + 1; i++)
            for (j = 0; j < 2 * r + 1; j++) begin
               win[n] = shadow_lines[line_addr(out_row + i - r, out_col + j - r)];
               n++;
            end
         for (i = 1; i < n; i++) begin
            v = win[i];
            j = i;
            while (j > 0 && win[j - 1] > v) begin
               win[j] = win[j - 1];
               j--;
            end
            win[j] = v;
         end
         res.pixel_out = win[n / 2];
      end else begin
         res.pixel_out = shadow_lines[line_addr(out_row, out_col)];
      end
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.frame_end = last;
      if (last) begin
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         fill_count = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
      return 1;
   endfunction

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // request driver
   always @(posedge clock) begin
      rsp_pkt_type res;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            req_count++;
            if (filter_step(req_payload, res)) pixel_exp_q = {pixel_exp_q, res};
         end
         if (!req_valid || req_ready) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= request_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      rsp_pkt_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (pixel_exp_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, got pixel %0d end %0b",
                        $time, rsp_payload.pixel_out, rsp_payload.frame_end);
            end else begin
               want = pixel_exp_q.pop_front();
               if (rsp_payload.pixel_out !== want.pixel_out) begin
                  fail_count++;
                  $display("%0t: pixel_out expected %0d actual %0d", $time,
                           want.pixel_out, rsp_payload.pixel_out);
               end
               if (rsp_payload.frame_end !== want.frame_end) begin
                  fail_count++;
                  $display("%0t: frame_end expected %0b actual %0b", $time,
                           want.frame_end, rsp_payload.frame_end);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_req != hold_done) begin
            hold_done++;
            hold_left = HoldCycles;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input int value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_config(input int w, input int h, input int k);
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
      csr_write(REG_KERNEL_SIZE, k);
      cfg_width  = w & 11'h7ff;
      cfg_height = h & 11'h7ff;
      cfg_kernel = k & 3'h7;
   endtask

   task automatic push_request(input logic op, input logic [7:0] px);
      req_pkt_type rq;
      rq.operation = op;
      rq.pixel_in  = px;
      request_q = {request_q, rq};
   endtask

   // wait until every request went in and every result came out
   task automatic wait_drained();
      while (request_q.size() != 0 || req_valid || pixel_exp_q.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // one frame of random pixels plus drains, with stray and broken items
   task automatic queue_frame(input bit noisy, input bit cut_short);
      int total, stop_at, i;
      total   = eff_w() * eff_h() + pipe_lag();
      stop_at = cut_short ? $urandom_range(total - 1) : total;
      for (i = 0; i < stop_at; i++) begin
         if (i < eff_w() * eff_h()) begin
            // a drain during the pixel phase is dropped by the block
            if (noisy && $urandom_range(19) == 0) push_request(OP_DRAIN, 8'($urandom));
            push_request(OP_PIXEL, 8'($urandom));
         end else if (noisy && $urandom_range(11) == 0) begin
            push_request(OP_PIXEL, 8'($urandom));
         end else begin
            push_request(OP_DRAIN, 8'($urandom));
         end
         queued_items++;
      end
      frame_count++;
   endtask

   task automatic set_idling(input int mode);
      case (mode % 4)
         0: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 59;
            rsp_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            rsp_stall_pct = 59;
         end
         default: begin
            send_idle_pct = 23;
            rsp_stall_pct = 23;
         end
      endcase
   endtask

   initial begin
      int i, nframes;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      rsp_ready     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_req      = 0;
      hold_done     = 0;
      hold_left     = 0;
      fail_count    = 0;
      req_count     = 0;
      rsp_count     = 0;
      frame_count   = 0;
      phase_count   = 0;
      queued_items  = 0;
      quiet_cycles  = 0;
      in_col        = 0;
      in_row        = 0;
      out_col       = 0;
      out_row       = 0;
      fill_count    = 0;
      cfg_width     = 640;
      cfg_height    = 480;
      cfg_kernel    = 3;
      for (i = 0; i < MemDepth; i++) shadow_lines[i] = 8'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed 3x3 frame: pixel extremes, stray drain, pixel in drain phase
      set_config(3, 3, 3);
      push_request(OP_PIXEL, 8'd0);
      push_request(OP_PIXEL, 8'd255);
      push_request(OP_DRAIN, 8'd17);
      push_request(OP_PIXEL, 8'd128);
      push_request(OP_PIXEL, 8'd255);
      push_request(OP_PIXEL, 8'd1);
      push_request(OP_PIXEL, 8'd254);
      push_request(OP_PIXEL, 8'd0);
      push_request(OP_PIXEL, 8'd127);
      push_request(OP_PIXEL, 8'd255);
      push_request(OP_PIXEL, 8'd9);
      push_request(OP_DRAIN, 8'd0);
      queued_items += 11;
      wait_drained();

      // zero-valued registers: one-pixel frames, filtering off
      set_config(0, 0, 0);
      push_request(OP_DRAIN, 8'd3);
      push_request(OP_PIXEL, 8'd200);
      push_request(OP_PIXEL, 8'd55);
      queued_items += 2;
      wait_drained();

      // largest kernel, and a bare kernel of one
      set_config(2, 2, 7);
      queue_frame(1'b0, 1'b0);
      wait_drained();
      set_config(3, 2, 1);
      queue_frame(1'b0, 1'b0);
      wait_drained();

      // width beyond the line store, single row, both idle sides
      set_config(2047, 1, 0);
      set_idling(3);
      queue_frame(1'b0, 1'b0);
      wait_drained();

      // tallest setting, broken off mid-frame
      set_config(1, 2047, 5);
      set_idling(0);
      for (i = 0; i < 12; i++) begin
         push_request(OP_PIXEL, 8'($urandom));
         queued_items++;
      end
      wait_drained();

      // long receiver hold-off while the sender keeps going
      set_config(8, 8, 3);
      hold_req++;
      queue_frame(1'b1, 1'b0);
      wait_drained();

      // random frame phases
      while (queued_items < ItemTarget) begin
         phase_count++;
         set_idling(phase_count);
         if ($urandom_range(3) == 0)
            set_config($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(7));
         else
            set_config($urandom_range(3, 14), $urandom_range(3, 10), $urandom_range(7));
         nframes = $urandom_range(1, 3);
         for (i = 0; i < nframes; i++)
            queue_frame($urandom_range(3) == 0, $urandom_range(9) == 0);
         wait_drained();
      end

      $display("%0d requests accepted, %0d pixels checked", req_count, rsp_count);
      $display("%0d frames over %0d random phases, kernels 0..7, four idling modes",
               frame_count, phase_count);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### files.f
rtl/mwf_pkg.sv
rtl/mwf_csr.sv
rtl/median_window_filter.sv
rtl/mwf_checker.sv
sim/median_window_filter_tb.sv
